[rtl/core/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants for the pixel invert / sRGB gray block
// Holds the luma weights, the word types, and the sRGB code thresholds.
// The threshold table is computed at elaboration in exact integer math.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

	// Widths of the datapath
	localparam int CHAN_BITS        = 8;
	localparam int SUM_BITS         = 24;
	localparam int GAMMA_INDEX_BITS = 12;
	localparam int CODE_BITS        = 8;
	localparam int NUM_CODES        = 1 << CODE_BITS;
	localparam int BIG_BITS         = 384;

	// Rec.709 weights in Q0.16
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// Threshold generation constants
	localparam int     FULL_SCALE  = 16711680;   // 255 * 65536
	localparam int     LIN_LAST    = 10;         // last code on the linear segment
	localparam longint LIN_NUM     = 64'd6553600;
	localparam longint LIN_DEN     = 64'd1292;
	localparam int     GAMMA_BASE  = 269025;
	localparam int     GAMMA_STEP  = 1000;
	localparam int     GAMMA_OFS   = 14025;
	localparam int     ROOT_POW    = 12;
	localparam int     SUM_POW     = 5;

	typedef enum logic {
		MODE_INVERT = 1'b0,
		MODE_GRAY   = 1'b1
	} mode_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] red;
	} pixel_t;

	// Control carried alongside each word
	typedef struct packed {
		logic  vld;
		mode_t mode;
	} tag_t;

	typedef logic [NUM_CODES-1:0][SUM_BITS-1:0] thr_table_t;

	// Smallest luma sum that reaches each output code
	function automatic thr_table_t build_thr();
		thr_table_t          t;
		logic [BIG_BITS-1:0] base;
		logic [BIG_BITS-1:0] rhs;
		logic [BIG_BITS-1:0] lhs;
		logic [SUM_BITS:0]   lo;
		logic [SUM_BITS:0]   hi;
		logic [SUM_BITS:0]   mid;
		longint              lin;
		int                  v;
		int                  k;
		int                  n;
		t = '0;
		// linear segment: ceil(v * 6553600 / 1292)
		for (v = 1; v <= LIN_LAST; v++) begin
			lin = (longint'(v) * LIN_NUM + LIN_DEN - 64'd1) / LIN_DEN;
			t[v] = SUM_BITS'(lin);
		end
		base = BIG_BITS'(1);
		for (k = 0; k < ROOT_POW; k++) begin
			base = base * BIG_BITS'(GAMMA_BASE);
		end
		// power segment: m^5 * 269025^12 >= (1000v+14025)^12 * FULL_SCALE^5
		for (v = LIN_LAST + 1; v < NUM_CODES; v++) begin
			rhs = BIG_BITS'(1);
			for (k = 0; k < ROOT_POW; k++) begin
				rhs = rhs * BIG_BITS'(GAMMA_STEP * v + GAMMA_OFS);
			end
			for (k = 0; k < SUM_POW; k++) begin
				rhs = rhs * BIG_BITS'(FULL_SCALE);
			end
			lo = '0;
			hi = (SUM_BITS + 1)'(FULL_SCALE);
			for (n = 0; n <= SUM_BITS; n++) begin
				if (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					lhs = base;
					for (k = 0; k < SUM_POW; k++) begin
						lhs = lhs * BIG_BITS'(mid);
					end
					if (lhs >= rhs) begin
						hi = mid;
					end else begin
						lo = mid + 1'b1;
					end
				end
			end
			t[v] = SUM_BITS'(lo);
		end
		return t;
	endfunction

	localparam thr_table_t THR = build_thr();

endpackage

`default_nettype wire

[rtl/core/pixel_invert_or_srgb_gray.sv]
// One BGR pixel word in, one word out, a new word accepted every clock while
// the output side keeps up. Each word passes eleven register stages, the
// first loaded at the accepting edge: two for the luma multiply and add,
// eight for the sRGB search (one code bit per stage against a constant
// threshold table), one for the output register. A stall on out_ready
// freezes the whole pipe; in_ready is high whenever the output register is
// empty or being drained. Mode 0 inverts each channel, mode 1 writes the
// sRGB-encoded Rec.709 gray to all three channels. The user must write the
// mode register through cfg_we/cfg_wdata only while the pipe is empty; the
// block does not enforce it. Each word keeps the mode it was accepted under.
// ----------------------------------------------------------------------------
// pixel_invert_or_srgb_gray: pixel inverter / sRGB grayscale converter top
// Mode register, handshake, luma and gamma pipelines, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_invert_or_srgb_gray (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [psg_pkg::CHAN_BITS-1:0]    blue_in,
	input  wire logic [psg_pkg::CHAN_BITS-1:0]    green_in,
	input  wire logic [psg_pkg::CHAN_BITS-1:0]    red_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [psg_pkg::CHAN_BITS-1:0]         blue_out,
	output logic [psg_pkg::CHAN_BITS-1:0]         green_out,
	output logic [psg_pkg::CHAN_BITS-1:0]         red_out
);

	psg_pkg::mode_t  mode_q;
	psg_pkg::tag_t   tag_in;
	psg_pkg::pixel_t pix_in;
	psg_pkg::tag_t   tag_l, tag_g;
	psg_pkg::pixel_t pix_l, pix_g;
	logic [psg_pkg::GAMMA_INDEX_BITS-1:0] idx_l;
	logic [psg_pkg::CODE_BITS-1:0]        code_g;
	logic            adv;
	logic            out_vld_q;
	psg_pkg::mode_t  out_mode_q;
	psg_pkg::pixel_t out_pix_q;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= psg_pkg::MODE_INVERT;
		end else if (cfg_we) begin
			mode_q <= psg_pkg::mode_t'(cfg_wdata);
		end
	end

	// whole pipe moves when the output register can take a word
	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	assign tag_in.vld  = in_valid;
	assign tag_in.mode = mode_q;
	assign pix_in      = '{blue: blue_in, green: green_in, red: red_in};

	psg_luma u_luma (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tag_in  (tag_in),
		.pix_in  (pix_in),
		.tag_out (tag_l),
		.pix_out (pix_l),
		.idx_out (idx_l)
	);

	psg_gamma u_gamma (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tag_in   (tag_l),
		.pix_in   (pix_l),
		.idx_in   (idx_l),
		.tag_out  (tag_g),
		.pix_out  (pix_g),
		.code_out (code_g)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tag_g.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_mode_q <= tag_g.mode;
			if (tag_g.mode == psg_pkg::MODE_GRAY) begin
				out_pix_q <= '{blue: code_g, green: code_g, red: code_g};
			end else begin
				out_pix_q <= ~pix_g;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign blue_out  = out_pix_q.blue;
	assign green_out = out_pix_q.green;
	assign red_out   = out_pix_q.red;

	// gray words carry one value on all channels
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_mode_q == psg_pkg::MODE_GRAY |->
			blue_out == green_out && green_out == red_out)
		else $error("gray word with unequal channels");

	// mode only changes on a config write
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(mode_q))
		else $error("mode changed without a write");

	// a stall freezes the pipe tail
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tag_g) && $stable(code_g) && $stable(pix_g))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

[rtl/core/psg_luma.sv]
// ----------------------------------------------------------------------------
// psg_luma: luma sum front end
// Stage 1 forms the three weighted products, stage 2 adds them and keeps
// the top bits of the sum as the gamma index.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_luma (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  adv,
	input  wire psg_pkg::tag_t                         tag_in,
	input  wire psg_pkg::pixel_t                       pix_in,
	output psg_pkg::tag_t                              tag_out,
	output psg_pkg::pixel_t                            pix_out,
	output logic [psg_pkg::GAMMA_INDEX_BITS-1:0]       idx_out
);

	localparam int SB = psg_pkg::SUM_BITS;
	localparam int GB = psg_pkg::GAMMA_INDEX_BITS;

	psg_pkg::tag_t   tag_s1, tag_s2;
	psg_pkg::pixel_t pix_s1, pix_s2;
	logic [SB-1:0]   prod_r_s1, prod_g_s1, prod_b_s1;
	logic [SB-1:0]   sum;
	logic [GB-1:0]   idx_s2;

	// control flow of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	// stage 1: weighted products
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= pix_in;
			prod_r_s1 <= SB'(psg_pkg::W_RED)   * SB'(pix_in.red);
			prod_g_s1 <= SB'(psg_pkg::W_GREEN) * SB'(pix_in.green);
			prod_b_s1 <= SB'(psg_pkg::W_BLUE)  * SB'(pix_in.blue);
		end
	end

	// stage 2: sum fits in 24 bits (max 255 * 65536)
	assign sum = prod_r_s1 + prod_g_s1 + prod_b_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= pix_s1;
			idx_s2 <= sum[SB-1 -: GB];
		end
	end

	assign tag_out = tag_s2;
	assign pix_out = pix_s2;
	assign idx_out = idx_s2;

endmodule

`default_nettype wire

[rtl/core/psg_gamma.sv]
// ----------------------------------------------------------------------------
// psg_gamma: sRGB encode by pipelined binary search
// One code bit per stage, MSB first: each stage tries setting its bit and
// keeps it when the threshold of the candidate code is at or below the level.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_gamma (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  adv,
	input  wire psg_pkg::tag_t                         tag_in,
	input  wire psg_pkg::pixel_t                       pix_in,
	input  wire logic [psg_pkg::GAMMA_INDEX_BITS-1:0]  idx_in,
	output psg_pkg::tag_t                              tag_out,
	output psg_pkg::pixel_t                            pix_out,
	output logic [psg_pkg::CODE_BITS-1:0]              code_out
);

	localparam int SB = psg_pkg::SUM_BITS;
	localparam int GB = psg_pkg::GAMMA_INDEX_BITS;
	localparam int CB = psg_pkg::CODE_BITS;

	psg_pkg::tag_t   tag_s  [CB];
	psg_pkg::pixel_t pix_s  [CB];
	logic [CB-1:0]   code_s [CB];
	logic [GB-1:0]   idx_s  [CB-1];

	for (genvar k = 0; k < CB; k++) begin : g_step
		psg_pkg::tag_t   tag_prev;
		psg_pkg::pixel_t pix_prev;
		logic [CB-1:0]   code_prev;
		logic [CB-1:0]   cand;
		logic [GB-1:0]   idx_prev;
		logic [SB-1:0]   level;

		if (k == 0) begin : g_first
			assign tag_prev  = tag_in;
			assign pix_prev  = pix_in;
			assign code_prev = '0;
			assign idx_prev  = idx_in;
		end else begin : g_next
			assign tag_prev  = tag_s[k-1];
			assign pix_prev  = pix_s[k-1];
			assign code_prev = code_s[k-1];
			assign idx_prev  = idx_s[k-1];
		end

		// lower bound of the index interval
		assign level = {idx_prev, {(SB - GB){1'b0}}};
		assign cand  = code_prev | (CB'(1) << (CB - 1 - k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (adv) begin
				tag_s[k] <= tag_prev;
			end
		end

		// ties go to the higher code
		always_ff @(posedge clk) begin
			if (adv) begin
				pix_s[k]  <= pix_prev;
				code_s[k] <= (psg_pkg::THR[cand] <= level) ? cand : code_prev;
			end
		end

		if (k < CB - 1) begin : g_idx
			always_ff @(posedge clk) begin
				if (adv) begin
					idx_s[k] <= idx_prev;
				end
			end
		end
	end

	assign tag_out  = tag_s[CB-1];
	assign pix_out  = pix_s[CB-1];
	assign code_out = code_s[CB-1];

endmodule

`default_nettype wire
